>>> rtl/core/stt_pkg.sv
package stt_pkg;

    // Field widths fixed by the stream formats.
    localparam int ID_W        = 4;
    localparam int CNT_W       = 32;
    localparam int MAX_REPORTS = 16;
    localparam int FOUND_W     = $clog2(MAX_REPORTS + 1);

    // Command codes carried on s_tuser.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_POLL  = 2'd3
    } cmd_t;

    // Poll sequencer states.
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_RUN,
        SCAN_FLUSH
    } scan_state_t;

    // Write request from the command decoder to the table.
    typedef struct packed {
        logic             en;
        logic             active;
        logic [CNT_W-1:0] deadline;
        logic             act;
    } stt_set_t;

    // Registered read result of the table.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] deadline;
        logic             act;
    } stt_rd_t;

endpackage

>>> rtl/core/stt_table.sv
module stt_table #(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  stt_pkg::stt_set_t  set_req,
    input  logic [IDX_W-1:0]   set_idx,
    input  logic               clr_en,
    input  logic [IDX_W-1:0]   clr_idx,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_idx,
    output stt_pkg::stt_rd_t   rd
);

    // Deadline and action bit of each entry; one write and one read port.
    logic [stt_pkg::CNT_W:0]  mem [NUM_TIMERS];
    // Per-entry active bits, cleared at once by reset.
    logic [NUM_TIMERS-1:0]    valid_reg;
    logic [NUM_TIMERS-1:0]    valid_next;
    logic                     rd_valid_reg;
    logic [stt_pkg::CNT_W:0]  rd_data_reg;

    // Memory write on a set request.
    always_ff @(posedge aclk) begin
        if (set_req.en) begin
            mem[set_idx] <= {set_req.deadline, set_req.act};
        end
    end

    // Registered memory read; the data holds between reads.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // Active bits: a set with a zero deadline leaves the entry inactive.
    always_comb begin
        valid_next = valid_reg;
        if (set_req.en) begin
            valid_next[set_idx] = set_req.active;
        end
        if (clr_en) begin
            valid_next[clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd.valid    = rd_valid_reg;
    assign rd.deadline = rd_data_reg[stt_pkg::CNT_W:1];
    assign rd.act      = rd_data_reg[0];

    // A set and a clear never arrive together: clears from a poll only run while busy.
    a_no_set_and_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(set_req.en && clr_en))
        else $error("table set and clear in the same cycle");

    // An active entry read back always carries a non-zero deadline.
    a_active_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (rd_data_reg[stt_pkg::CNT_W:1] != '0))
        else $error("active entry with zero deadline");

    // An entry written active has its active bit set by the write.
    a_set_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (set_req.en && set_req.active) |=> valid_reg[$past(set_idx)])
        else $error("set entry not marked active");

endmodule

>>> rtl/core/stt_scan.sv
module stt_scan #(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [stt_pkg::CNT_W-1:0]  tick_count,
    input  stt_pkg::stt_rd_t           rd,
    output logic                       rd_en,
    output logic [IDX_W-1:0]           rd_idx,
    output logic                       clr_en,
    output logic [IDX_W-1:0]           clr_idx,
    output logic                       busy,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [3:0] expired_id, [4] action_present
    output logic                       m_tlast
);

    stt_pkg::scan_state_t          state_reg, state_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic                          issue_done_reg, issue_done_next;
    logic                          chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]              chk_idx_reg, chk_idx_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [stt_pkg::ID_W-1:0]      pend_id_reg, pend_id_next;
    logic                          pend_act_reg, pend_act_next;
    logic [stt_pkg::FOUND_W-1:0]   found_reg, found_next;
    logic                          out_valid_reg, out_valid_next;
    logic [stt_pkg::ID_W-1:0]      out_id_reg, out_id_next;
    logic                          out_act_reg, out_act_next;
    logic                          out_last_reg, out_last_next;

    logic                          out_free;
    logic                          expired;
    logic                          stall;
    logic                          limit_hit;
    logic                          push;

    assign out_free = !out_valid_reg || m_tready;
    assign expired  = chk_valid_reg && rd.valid && (tick_count > rd.deadline);
    assign stall    = expired && pend_valid_reg && !out_free;
    assign limit_hit = expired &&
        (found_reg == stt_pkg::FOUND_W'(stt_pkg::MAX_REPORTS - 1));

    // Sequencer: reads one entry per cycle unless an expired entry waits on a full output.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_act_next   = pend_act_reg;
        found_next      = found_reg;
        out_id_next     = out_id_reg;
        out_act_next    = out_act_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        clr_en          = 1'b0;
        push            = 1'b0;
        unique case (state_reg)
            stt_pkg::SCAN_IDLE: begin
                if (start) begin
                    state_next      = stt_pkg::SCAN_RUN;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    chk_valid_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    found_next      = '0;
                end
            end
            stt_pkg::SCAN_RUN: begin
                if (!stall) begin
                    rd_en          = !issue_done_reg && !limit_hit;
                    chk_valid_next = rd_en;
                    chk_idx_next   = idx_reg;
                    if (rd_en) begin
                        idx_next        = idx_reg + 1'b1;
                        issue_done_next = (idx_reg == IDX_W'(NUM_TIMERS - 1));
                    end
                    // An expired entry is retired and becomes the pending report;
                    // the previous one leaves as a non-final result.
                    if (expired) begin
                        clr_en          = 1'b1;
                        found_next      = found_reg + 1'b1;
                        pend_valid_next = 1'b1;
                        pend_id_next    = stt_pkg::ID_W'(chk_idx_reg);
                        pend_act_next   = rd.act;
                        if (pend_valid_reg) begin
                            push          = 1'b1;
                            out_id_next   = pend_id_reg;
                            out_act_next  = pend_act_reg;
                            out_last_next = 1'b0;
                        end
                    end
                    if (!rd_en) begin
                        state_next = stt_pkg::SCAN_FLUSH;
                    end
                end
            end
            stt_pkg::SCAN_FLUSH: begin
                // The final pending report carries the last marker.
                if (!pend_valid_reg) begin
                    state_next = stt_pkg::SCAN_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    out_id_next     = pend_id_reg;
                    out_act_next    = pend_act_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = stt_pkg::SCAN_IDLE;
                end
            end
            default: begin
                state_next = stt_pkg::SCAN_IDLE;
            end
        endcase
        out_valid_next = push || (out_valid_reg && !m_tready);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= stt_pkg::SCAN_IDLE;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
            found_reg      <= '0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            issue_done_reg <= issue_done_next;
            found_reg      <= found_next;
            idx_reg        <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        chk_idx_reg  <= chk_idx_next;
        pend_id_reg  <= pend_id_next;
        pend_act_reg <= pend_act_next;
        out_id_reg   <= out_id_next;
        out_act_reg  <= out_act_next;
        out_last_reg <= out_last_next;
    end

    assign rd_idx   = idx_reg;
    assign clr_idx  = chk_idx_reg;
    assign busy     = (state_reg != stt_pkg::SCAN_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_act_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

    // A result is only loaded into a free output register.
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("result overwrote a waiting result");

    // No more reports per poll than the limit.
    a_found_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg <= stt_pkg::FOUND_W'(stt_pkg::MAX_REPORTS))
        else $error("too many reports in one poll");

    // An idle sequencer holds no checked entry and no pending report.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stt_pkg::SCAN_IDLE) |-> (!chk_valid_reg && !pend_valid_reg))
        else $error("idle with work left");

    // Leaving the flush state always delivers the final report if one was pending.
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stt_pkg::SCAN_FLUSH && pend_valid_reg && out_free)
            |=> (out_valid_reg && out_last_reg))
        else $error("final report missing its last marker");

endmodule

>>> rtl/core/software_timer_table_unit.sv
// Tick, set and clear: the count or the table updates at the accepting edge.
// Poll: s_tready stays low until the scan ends and the final report is loaded; one table
// entry is read per cycle through the single read port of the deadline memory, while no
// output stall holds the scan. Each result passes the check and pending registers to the
// output; later results follow at most one per cycle, as further expired entries are found.
// Reset (aresetn low, synchronous) clears the tick count and all entry active bits at once.
module software_timer_table_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] timer_id, [35:4] delay, [36] has_action
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] expired_id, [4] action_present
    output logic        m_tlast    // last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [stt_pkg::CNT_W-1:0] tick_count_reg, tick_count_next;
    logic                      s_accept;
    stt_pkg::cmd_t             cmd;
    logic [stt_pkg::ID_W-1:0]  s_id;
    logic [stt_pkg::CNT_W-1:0] s_delay;
    logic                      s_act;
    logic                      id_ok;
    logic [stt_pkg::CNT_W-1:0] set_sum;
    stt_pkg::stt_set_t         set_req;
    logic                      cmd_clr;
    logic                      poll_start;
    logic                      busy;
    logic                      scan_rd_en;
    logic [IDX_W-1:0]          scan_rd_idx;
    logic                      scan_clr_en;
    logic [IDX_W-1:0]          scan_clr_idx;
    logic                      tbl_clr_en;
    logic [IDX_W-1:0]          tbl_clr_idx;
    stt_pkg::stt_rd_t          tbl_rd;

    // Request decode; a request is taken only while no poll is running.
    assign s_tready   = !busy;
    assign s_accept   = s_tvalid && s_tready;
    assign cmd        = stt_pkg::cmd_t'(s_tuser);
    assign s_id       = s_tdata[3:0];
    assign s_delay    = s_tdata[35:4];
    assign s_act      = s_tdata[36];
    assign id_ok      = (32'(s_id) < NUM_TIMERS);
    assign poll_start = s_accept && (cmd == stt_pkg::CMD_POLL);
    assign cmd_clr    = s_accept && (cmd == stt_pkg::CMD_CLEAR) && id_ok;

    // Absolute deadline; a sum that wraps to zero leaves the entry inactive.
    assign set_sum          = s_delay + tick_count_reg;
    assign set_req.en       = s_accept && (cmd == stt_pkg::CMD_SET) && id_ok;
    assign set_req.active   = (set_sum != '0);
    assign set_req.deadline = set_sum;
    assign set_req.act      = s_act;

    // Clears come from a clear request or from expiries found by a poll.
    assign tbl_clr_en  = cmd_clr || scan_clr_en;
    assign tbl_clr_idx = scan_clr_en ? scan_clr_idx : IDX_W'(s_id);

    // Tick count, advanced by one on each accepted tick command.
    always_comb begin
        tick_count_next = tick_count_reg;
        if (s_accept && (cmd == stt_pkg::CMD_TICK)) begin
            tick_count_next = tick_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
        end else begin
            tick_count_reg <= tick_count_next;
        end
    end

    stt_table #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .set_req (set_req),
        .set_idx (IDX_W'(s_id)),
        .clr_en  (tbl_clr_en),
        .clr_idx (tbl_clr_idx),
        .rd_en   (scan_rd_en),
        .rd_idx  (scan_rd_idx),
        .rd      (tbl_rd)
    );

    stt_scan #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (poll_start),
        .tick_count (tick_count_reg),
        .rd         (tbl_rd),
        .rd_en      (scan_rd_en),
        .rd_idx     (scan_rd_idx),
        .clr_en     (scan_clr_en),
        .clr_idx    (scan_clr_idx),
        .busy       (busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
